// ----- hdl/rbc_pkg.sv -----
// Shared types, constants and the modulo-65535 fold for the recurrence byte checksum.
// No dependencies; imported by rbc_term and recurrence_byte_checksum_unit.
package rbc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TermW = 16;
  // Widest signed-magnitude difference: (9-bit factor) x (16-bit term)
  localparam int unsigned ProdW = 25;

  localparam logic [ByteW-1:0] SeedOffset = 8'd7;
  localparam logic [ByteW-1:0] AlphaMul   = 8'd17;
  localparam logic [ByteW-1:0] BetaMul    = 8'd31;
  localparam logic [TermW-1:0] FoldMod    = 16'hFFFF;
  localparam logic [TermW-1:0] TermOne    = 16'd1;
  localparam logic [ByteW-1:0] IndexOne   = 8'd1;

  // Recurrence state carried from beat to beat
  typedef struct packed {
    logic [TermW-1:0] older;
    logic [TermW-1:0] current;
    logic [ByteW-1:0] index;
  } rbc_state_t;

  // End-around fold: value mod 65535, result 0..65534
  function automatic logic [TermW-1:0] rbc_fold(input logic [ProdW-1:0] v);
    logic [TermW:0] x;
    x = {1'b0, v[TermW-1:0]} + {{(2*TermW+1-ProdW){1'b0}}, v[ProdW-1:TermW]};
    if (x >= {1'b0, FoldMod}) begin
      x = x - {1'b0, FoldMod};
    end
    return x[TermW-1:0];
  endfunction

endpackage

// ----- hdl/rbc_term.sv -----
// Next-term logic of the recurrence: two small multiplies, a signed difference
// and a fold modulo 65535. Depends on rbc_pkg.
module rbc_term
  import rbc_pkg::*;
(
  input  logic [ByteW-1:0] data_byte,
  input  rbc_state_t       state,
  output logic [TermW-1:0] next_term
);

  logic [ByteW-1:0] alpha;
  logic [ByteW-1:0] beta;
  logic [ByteW:0]   factor;
  logic [ProdW-1:0] pos;
  logic [ProdW-1:0] neg;
  logic [ProdW-1:0] diff;
  logic [TermW-1:0] folded;
  logic             negative;

  // Index-dependent coefficients, both taken modulo 256
  assign alpha  = ByteW'(state.index * AlphaMul);
  assign beta   = ByteW'(state.index * BetaMul);
  assign factor = {1'b0, data_byte} + {1'b0, alpha};

  // Both products, operands widened so the full product is kept
  assign pos = ProdW'(factor) * ProdW'(state.current);
  assign neg = ProdW'(beta) * ProdW'(state.older);

  // Magnitude of the difference and its sign
  assign negative = (pos < neg);
  assign diff     = negative ? (neg - pos) : (pos - neg);
  assign folded   = rbc_fold(diff);

  // Negative case wraps to (1 - d) mod 65535
  always_comb begin
    if (!negative) begin
      next_term = folded;
    end else if (folded == '0) begin
      next_term = TermOne;
    end else if (folded == TermOne) begin
      next_term = '0;
    end else begin
      next_term = TermW'({1'b0, FoldMod} + {1'b0, TermOne} - {1'b0, folded});
    end
  end

endmodule

// ----- hdl/recurrence_byte_checksum_unit.sv -----
// Top level of the recurrence byte checksum: input register, recurrence state,
// result register and stream handshakes. Depends on rbc_pkg and rbc_term.
//
// Usage:
//   Message bytes enter on the in_ channel, one per beat: in_tdata carries the
//   byte, in_tuser flags the first byte of a message (restarts the recurrence)
//   and in_tlast the final byte. Only a beat with in_tlast set yields a result:
//   one beat on the out_ channel carrying the 16-bit checksum.
//   Timing: the beat is captured in the input register at its accepting edge
//   and the state and result register load from it when it advances, so
//   out_tvalid rises once a held last byte advances. Throughput is one byte per
//   cycle while no last byte waits on a full result register; the combinational
//   update of the two recurrence terms through rbc_term sets it.
//   The input register accepts a new beat while a finished checksum waits in
//   the result register. When the receiver stalls, bytes that produce no
//   result still drain; a last byte waits in the input register until the
//   result register frees, and in_tready is low while it waits.
//   Reset (rst_n low, synchronous) empties both registers and sets the state
//   to older term 1, current term 1, index 0. A byte without a start flag
//   continues from whatever state is held.
module recurrence_byte_checksum_unit
  import rbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,   // [7:0] data_byte
  input  logic             in_tuser,   // [0] first_byte
  input  logic             in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [TermW-1:0] out_tdata   // [15:0] checksum
);

  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_first_r;
  logic             in_last_r;

  rbc_state_t       state_r;
  rbc_state_t       state_nxt;
  logic [TermW-1:0] term;

  logic             out_valid_r;
  logic [TermW-1:0] out_data_r;

  logic             advance;

  // Held beat moves on unless it carries a result and the result slot is full
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
  end

  rbc_term u_term (
    .data_byte (in_byte_r),
    .state     (state_r),
    .next_term (term)
  );

  // Next recurrence state: seed on a first byte, otherwise shift terms
  always_comb begin
    if (in_first_r) begin
      state_nxt.older   = TermOne;
      state_nxt.current = TermW'({1'b0, in_byte_r} + {1'b0, SeedOffset});
      state_nxt.index   = IndexOne;
    end else begin
      state_nxt.older   = state_r.current;
      state_nxt.current = term;
      state_nxt.index   = state_r.index + IndexOne;
    end
  end

  // Recurrence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.older   <= TermOne;
      state_r.current <= TermOne;
      state_r.index   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_data_r <= state_nxt.current;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
